// ===== rtl/core/scrd_pkg.sv =====
`timescale 1ns / 1ps

package scrd_pkg;

	// Field widths fixed by the item formats
	localparam int OP_W       = 2;
	localparam int SLOT_W     = 10;
	localparam int VALUE_W    = 16;
	localparam int ENTRY_W    = 10;
	localparam int NIBBLE_W   = 4;
	localparam int SUM_W      = 40;
	localparam int LEVEL_W    = 13;
	localparam int STEP_W     = 12;
	localparam int ROW_LEN_W  = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_LOAD_VECTOR = 2'd0;
	localparam op_t OP_LOAD_ORDER  = 2'd1;
	localparam op_t OP_CODE        = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_USE_ORDER = 2'd0;
	localparam cfg_idx_t REG_ROW_LEN   = 2'd1;

	typedef logic signed [LEVEL_W-1:0] level_t;
	localparam level_t LEVEL_START = -13'sd2047;
	localparam level_t LEVEL_MAX   = 13'sd4095;

	localparam logic [NIBBLE_W-1:0]  ESCAPE_CODE   = 4'd15;
	localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 11'd768;

	typedef logic signed [SUM_W-1:0] sum_t;
	localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// Escape sequence position
	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_LOW,
		ESC_MID,
		ESC_HIGH
	} esc_phase_t;

	typedef struct packed {
		op_t                        operation;
		logic [SLOT_W-1:0]          slot;
		logic signed [VALUE_W-1:0]  vector_value;
		logic [ENTRY_W-1:0]         order_entry;
		logic [NIBBLE_W-1:0]        code_nibble;
	} cmd_t;

	typedef struct packed {
		sum_t row_sum;
		logic level_overflow;
	} res_t;

	// Control for one decoded weight
	typedef struct packed {
		logic valid;
		logic last;
		logic ovf;
	} wctl_t;

endpackage

// ===== rtl/core/scrd_chan_if.sv =====
`timescale 1ns / 1ps

interface scrd_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/scrd_ram.sv =====
`timescale 1ns / 1ps

module scrd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end
endmodule

// ===== rtl/core/scrd_decode.sv =====
`timescale 1ns / 1ps

module scrd_decode #(
	parameter int MAX_ROW_LEN = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic [scrd_pkg::NIBBLE_W-1:0]  code_nibble,
	input  logic [scrd_pkg::ROW_LEN_W-1:0] row_length,
	output scrd_pkg::wctl_t                wctl,
	output scrd_pkg::level_t               level,
	output logic [$clog2(MAX_ROW_LEN)-1:0] pos
);
	import scrd_pkg::*;

	localparam int AW   = $clog2(MAX_ROW_LEN);
	localparam int CW   = $clog2(MAX_ROW_LEN + 1);
	localparam int CMPW = (CW > ROW_LEN_W) ? CW : ROW_LEN_W;

	esc_phase_t          phase_q, phase_nxt;
	logic [STEP_W-1:0]   esc_q, esc_nxt;
	logic [STEP_W-1:0]   step;
	logic                apply;
	level_t              level_q;
	logic [CW-1:0]       done_q;
	logic                ovf_q;
	logic signed [LEVEL_W:0] lvl_sum;
	logic                sat;
	level_t              lvl_new;
	logic [CMPW-1:0]     rl_ext;
	logic [CMPW-1:0]     eff_len;
	logic [CMPW-1:0]     done_inc;
	logic                last;

	// Escape sequencing: gather three digits, low first
	always_comb begin
		phase_nxt = phase_q;
		esc_nxt   = esc_q;
		apply     = 1'b0;
		step      = '0;
		case (phase_q)
			ESC_NONE: begin
				if (code_nibble == ESCAPE_CODE) begin
					phase_nxt = ESC_LOW;
					esc_nxt   = '0;
				end else begin
					apply = 1'b1;
					step  = {8'd0, code_nibble};
				end
			end
			ESC_LOW: begin
				esc_nxt   = {8'd0, code_nibble};
				phase_nxt = ESC_MID;
			end
			ESC_MID: begin
				esc_nxt   = {4'd0, code_nibble, esc_q[3:0]};
				phase_nxt = ESC_HIGH;
			end
			ESC_HIGH: begin
				apply     = 1'b1;
				step      = {code_nibble, esc_q[7:0]};
				esc_nxt   = '0;
				phase_nxt = ESC_NONE;
			end
			default: begin
				phase_nxt = ESC_NONE;
				esc_nxt   = '0;
			end
		endcase
	end

	// Step the level, saturate at the top
	assign lvl_sum = {level_q[LEVEL_W-1], level_q} + $signed({2'b00, step});
	assign sat     = lvl_sum > $signed({1'b0, LEVEL_MAX});
	assign lvl_new = sat ? LEVEL_MAX : lvl_sum[LEVEL_W-1:0];

	// Clamp the row length and detect the row end
	assign rl_ext   = CMPW'(row_length);
	assign eff_len  = (rl_ext == '0) ? CMPW'(1) :
		((rl_ext > CMPW'(MAX_ROW_LEN)) ? CMPW'(MAX_ROW_LEN) : rl_ext);
	assign done_inc = CMPW'(done_q) + CMPW'(1);
	assign last     = done_inc >= eff_len;

	assign wctl.valid = take && apply;
	assign wctl.last  = last;
	assign wctl.ovf   = ovf_q || sat;
	assign level      = lvl_new;
	assign pos        = done_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ESC_NONE;
		end else if (take) begin
			phase_q <= phase_nxt;
		end
	end

	// Advance the escape state on each taken nibble and the row state on each decoded weight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= '0;
			level_q <= LEVEL_START;
			done_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			esc_q <= esc_nxt;
			if (apply) begin
				if (last) begin
					level_q <= LEVEL_START;
					done_q  <= '0;
					ovf_q   <= 1'b0;
				end else begin
					level_q <= lvl_new;
					done_q  <= done_inc[CW-1:0];
					ovf_q   <= ovf_q || sat;
				end
			end
		end
	end
endmodule

// ===== rtl/core/scrd_mac.sv =====
`timescale 1ns / 1ps

module scrd_mac #(
	parameter int VECTOR_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scrd_pkg::wctl_t               wctl_s2,
	input  scrd_pkg::level_t              level_s2,
	input  logic signed [VECTOR_BITS-1:0] vec_s2,
	input  logic                          res_ready,
	output logic                          res_valid,
	output scrd_pkg::res_t                res_data,
	output logic                          adv
);
	import scrd_pkg::*;

	localparam int PROD_W = LEVEL_W + VECTOR_BITS;

	logic signed [PROD_W-1:0] prod_s3;
	wctl_t                    wctl_s3;
	sum_t                     acc_q;
	logic signed [SUM_W:0]    sum_wide;
	sum_t                     sum_sat;
	logic                     res_valid_q;
	res_t                     res_q;

	// Stall only when a row end meets a full output register
	assign adv = !(wctl_s3.valid && wctl_s3.last && res_valid_q && !res_ready);

	// Multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wctl_s3 <= '0;
		end else if (adv) begin
			wctl_s3 <= wctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= PROD_W'(level_s2) * PROD_W'(vec_s2);
		end
	end

	// Accumulate with saturation
	assign sum_wide = (SUM_W + 1)'(acc_q) + (SUM_W + 1)'(prod_s3);
	assign sum_sat  = (sum_wide > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX :
		((sum_wide < (SUM_W + 1)'(SUM_MIN)) ? SUM_MIN : sum_wide[SUM_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (wctl_s3.valid && adv) begin
				acc_q <= wctl_s3.last ? '0 : sum_sat;
			end
			if (wctl_s3.valid && wctl_s3.last && adv) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Load the result register at row end
	always_ff @(posedge clk) begin
		if (wctl_s3.valid && wctl_s3.last && adv) begin
			res_q.row_sum        <= sum_sat;
			res_q.level_overflow <= wctl_s3.ovf;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;
endmodule

// ===== rtl/core/step_coded_row_dot_product_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                                             Handshake
// cmd       in   operation, slot, vector_value, order_entry, nibble  valid/ready
// res       out  row_sum (40b signed), level_overflow                valid/ready
// cfg       in   cfg_index, cfg_data                                 cfg_we
//
// One item per cycle is taken while cmd.ready is high. A weight nibble passes decode,
// order store read, vector store read, multiply and accumulate; at a row end the
// accumulated sum is then registered as the row result. Both stores are
// single-port-write RAMs, one read each.
// cmd.ready drops only while a row result waits in a full output register.
// Reset clears control and row state; store contents stay undefined until loaded.

module step_coded_row_dot_product_unit #(
	parameter int MAX_ROW_LEN = 1024,
	parameter int VECTOR_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	scrd_chan_if.sink                       cmd,
	scrd_chan_if.source                     res,
	input  logic                            cfg_we,
	input  logic [scrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scrd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import scrd_pkg::*;

	localparam int AW = $clog2(MAX_ROW_LEN);

	cmd_t                     cmd_p;
	logic                     accept;
	logic                     adv;
	logic                     use_order_q;
	logic [ROW_LEN_W-1:0]     row_length_q;
	wctl_t                    wctl_s0, wctl_s1, wctl_s2;
	level_t                   level_s0, level_s1, level_s2;
	logic [AW-1:0]            pos_s0, pos_s1;
	logic                     use_order_s1;
	logic [AW-1:0]            ord_rdata;
	logic [AW-1:0]            vec_raddr;
	logic [AW-1:0]            wr_slot;
	logic signed [31:0]       vec_wide;
	logic [VECTOR_BITS-1:0]   vec_rdata;
	logic                     res_valid_w;
	res_t                     res_data_w;

	// Reduce an index modulo the store depth by shifted compare-subtract
	function automatic logic [AW-1:0] wrap_index(input logic [SLOT_W-1:0] v);
		logic [17:0] r;
		r = 18'(v);
		for (int k = 5; k >= 0; k--) begin
			if (r >= (18'(MAX_ROW_LEN) << k)) begin
				r = r - (18'(MAX_ROW_LEN) << k);
			end
		end
		return r[AW-1:0];
	endfunction

	assign cmd_p     = cmd.payload;
	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_order_q  <= 1'b0;
			row_length_q <= ROW_LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_USE_ORDER: use_order_q  <= cfg_data[0];
				REG_ROW_LEN:   row_length_q <= cfg_data[ROW_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	scrd_decode #(
		.MAX_ROW_LEN(MAX_ROW_LEN)
	) u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (accept && (cmd_p.operation == OP_CODE)),
		.code_nibble (cmd_p.code_nibble),
		.row_length  (row_length_q),
		.wctl        (wctl_s0),
		.level       (level_s0),
		.pos         (pos_s0)
	);

	assign wr_slot  = wrap_index(cmd_p.slot);
	assign vec_wide = 32'(cmd_p.vector_value);

	// Order store: read at the weight position as the nibble is taken
	scrd_ram #(
		.WIDTH(AW),
		.DEPTH(MAX_ROW_LEN)
	) u_order_ram (
		.clk   (clk),
		.we    (accept && (cmd_p.operation == OP_LOAD_ORDER)),
		.waddr (wr_slot),
		.wdata (wrap_index(cmd_p.order_entry)),
		.re    (adv),
		.raddr (pos_s0),
		.rdata (ord_rdata)
	);

	// Gather stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wctl_s1 <= '0;
			wctl_s2 <= '0;
		end else if (adv) begin
			wctl_s1 <= wctl_s0;
			wctl_s2 <= wctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_s1     <= level_s0;
			pos_s1       <= pos_s0;
			use_order_s1 <= use_order_q;
			level_s2     <= level_s1;
		end
	end

	assign vec_raddr = use_order_s1 ? ord_rdata : pos_s1;

	// Vector store: read-first keeps a later load from leaking into this read
	scrd_ram #(
		.WIDTH(VECTOR_BITS),
		.DEPTH(MAX_ROW_LEN)
	) u_vector_ram (
		.clk   (clk),
		.we    (accept && (cmd_p.operation == OP_LOAD_VECTOR)),
		.waddr (wr_slot),
		.wdata (vec_wide[VECTOR_BITS-1:0]),
		.re    (adv),
		.raddr (vec_raddr),
		.rdata (vec_rdata)
	);

	scrd_mac #(
		.VECTOR_BITS(VECTOR_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.wctl_s2   (wctl_s2),
		.level_s2  (level_s2),
		.vec_s2    ($signed(vec_rdata)),
		.res_ready (res.ready),
		.res_valid (res_valid_w),
		.res_data  (res_data_w),
		.adv       (adv)
	);

	assign res.valid   = res_valid_w;
	assign res.payload = res_data_w;

	// A new result only follows a row-end weight at the accumulator
	a_result_from_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(u_mac.wctl_s3.valid && u_mac.wctl_s3.last))
		else $error("result appeared without a row end");

	// Input stalls only while a result is pending
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> res.valid)
		else $error("input stalled with empty output register");

	// Weight positions stay inside the stores
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wctl_s1.valid |-> (32'(pos_s1) < MAX_ROW_LEN))
		else $error("weight position beyond store depth");

	// Level stays within its start and saturation bounds
	a_level_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		wctl_s1.valid |-> (level_s1 >= LEVEL_START) && (level_s1 <= LEVEL_MAX))
		else $error("weight level out of range");
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import scrd_pkg::*;

	localparam int MAX_ROW_LEN = 1024;

	// Config indexes past the two defined registers and the unused operation
	localparam cfg_idx_t REG_SPARE_A = 2'd2;
	localparam cfg_idx_t REG_SPARE_B = 2'd3;
	localparam op_t      OP_UNUSED   = 2'd3;

	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 16'sh8000;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sh7FFF;
	localparam logic [SLOT_W-1:0]         SLOT_LAST = 10'd1023;
	localparam logic [NIBBLE_W-1:0]       NIBBLE_STEP_MAX = 4'd14;

	// Result-side stall patterns
	localparam int RX_FREE = 0;
	localparam int RX_COIN = 1;
	localparam int RX_SLOW = 2;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	scrd_chan_if #(.payload_t(cmd_t)) cmd_ch ();
	scrd_chan_if #(.payload_t(res_t)) res_ch ();

	step_coded_row_dot_product_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state: stores, row state and register copies
	logic signed [VALUE_W-1:0] vec_mirror [0:MAX_ROW_LEN-1];
	logic [ENTRY_W-1:0]        ord_mirror [0:MAX_ROW_LEN-1];
	bit                        vec_written [0:MAX_ROW_LEN-1];
	bit                        ord_written [0:MAX_ROW_LEN-1];
	level_t                    level_now;
	int unsigned               weights_done;
	esc_phase_t                esc_now;
	logic [STEP_W-1:0]         esc_step;
	sum_t                      acc;
	bit                        ovf_seen;
	bit                        order_on;
	logic [ROW_LEN_W-1:0]      row_len_cfg;

	res_t        expected_rows[$];
	int unsigned error_count = 0;
	int unsigned items_taken = 0;
	int unsigned burst_left = 0;
	bit          noise_on = 1'b0;
	int          stall_mode = RX_FREE;
	int unsigned stall_left = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void restart_row();
		level_now = LEVEL_START;
		weights_done = 0;
		esc_now = ESC_NONE;
		esc_step = '0;
		acc = '0;
		ovf_seen = 1'b0;
	endfunction

	function automatic int unsigned row_length_now();
		if (row_len_cfg == 0)
			return 1;
		if (row_len_cfg > MAX_ROW_LEN)
			return MAX_ROW_LEN;
		return row_len_cfg;
	endfunction

	// Add one step to the level and accumulate one product; 1 at row end
	function automatic bit apply_weight(input logic [STEP_W-1:0] step, output res_t row);
		int                 lv;
		logic [SLOT_W-1:0]  pos;
		logic [SLOT_W-1:0]  idx;
		longint             s;
		row = '0;
		lv = int'(level_now) + int'(step);
		if (lv > int'(LEVEL_MAX)) begin
			lv = int'(LEVEL_MAX);
			ovf_seen = 1'b1;
		end
		level_now = level_t'(lv);
		pos = SLOT_W'(weights_done % MAX_ROW_LEN);
		idx = order_on ? ord_mirror[pos] : pos;
		s = longint'(acc) + longint'(lv) * longint'(vec_mirror[idx]);
		if (s > longint'(SUM_MAX))
			s = longint'(SUM_MAX);
		if (s < longint'(SUM_MIN))
			s = longint'(SUM_MIN);
		acc = sum_t'(s);
		weights_done++;
		if (weights_done >= row_length_now()) begin
			row.row_sum = acc;
			row.level_overflow = ovf_seen;
			restart_row();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Update the predictor with one accepted item; 1 when a row result is due
	function automatic bit predict_item(input cmd_t c, output res_t row);
		bit made;
		made = 1'b0;
		row = '0;
		case (c.operation)
			OP_LOAD_VECTOR: begin
				vec_mirror[c.slot] = c.vector_value;
				vec_written[c.slot] = 1'b1;
			end
			OP_LOAD_ORDER: begin
				ord_mirror[c.slot] = c.order_entry;
				ord_written[c.slot] = 1'b1;
			end
			OP_CODE: begin
				case (esc_now)
					ESC_NONE: begin
						if (c.code_nibble == ESCAPE_CODE) begin
							esc_now = ESC_LOW;
							esc_step = '0;
						end else begin
							made = apply_weight(STEP_W'(c.code_nibble), row);
						end
					end
					ESC_LOW: begin
						esc_step[3:0] = c.code_nibble;
						esc_now = ESC_MID;
					end
					ESC_MID: begin
						esc_step[7:4] = c.code_nibble;
						esc_now = ESC_HIGH;
					end
					default: begin
						esc_step[11:8] = c.code_nibble;
						esc_now = ESC_NONE;
						made = apply_weight(esc_step, row);
						esc_step = '0;
					end
				endcase
			end
			default: ;
		endcase
		return made;
	endfunction

	function automatic bit completes_weight(input logic [NIBBLE_W-1:0] nib);
		return (esc_now == ESC_NONE && nib != ESCAPE_CODE) || esc_now == ESC_HIGH;
	endfunction

	function automatic cmd_t random_item(input op_t op);
		cmd_t c;
		c.operation = op;
		c.slot = SLOT_W'($urandom);
		c.vector_value = VALUE_W'($urandom);
		c.order_entry = ENTRY_W'($urandom);
		c.code_nibble = NIBBLE_W'($urandom);
		return c;
	endfunction

	// Drive one item, with random gaps between bursts, and hold until accepted
	task automatic send_item(input cmd_t c);
		res_t        row;
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			cmd_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		cmd_ch.valid = 1'b1;
		cmd_ch.payload = c;
		do @(posedge clk); while (!cmd_ch.ready);
		if (predict_item(c, row))
			expected_rows.push_back(row);
		if (c.operation != OP_UNUSED)
			items_taken++;
		burst_left--;
		@(negedge clk);
		cmd_ch.valid = 1'b0;
	endtask

	task automatic load_vector(input logic [SLOT_W-1:0] slot,
			input logic signed [VALUE_W-1:0] value);
		cmd_t c;
		c = random_item(OP_LOAD_VECTOR);
		c.slot = slot;
		c.vector_value = value;
		send_item(c);
	endtask

	task automatic load_order(input logic [SLOT_W-1:0] slot, input logic [ENTRY_W-1:0] entry);
		cmd_t c;
		c = random_item(OP_LOAD_ORDER);
		c.slot = slot;
		c.order_entry = entry;
		send_item(c);
	endtask

	task automatic send_ignored();
		send_item(random_item(OP_UNUSED));
	endtask

	task automatic send_noise();
		case ($urandom_range(0, 2))
			0: load_vector(SLOT_W'($urandom), VALUE_W'($urandom));
			1: load_order(SLOT_W'($urandom), ENTRY_W'($urandom));
			default: send_ignored();
		endcase
	endtask

	// Load whatever the next weight reads if it has never been written, and at random while noise is on
	task automatic prepare_weight_reads();
		logic [SLOT_W-1:0] pos;
		logic [SLOT_W-1:0] idx;
		pos = SLOT_W'(weights_done % MAX_ROW_LEN);
		idx = pos;
		if (order_on) begin
			if (!ord_written[pos] || (noise_on && $urandom_range(0, 15) == 0))
				load_order(pos, ENTRY_W'($urandom));
			idx = ord_mirror[pos];
		end
		if (!vec_written[idx] || (noise_on && $urandom_range(0, 15) == 0))
			load_vector(idx, VALUE_W'($urandom));
	endtask

	task automatic send_code(input logic [NIBBLE_W-1:0] nib);
		cmd_t c;
		if (noise_on && $urandom_range(0, 9) == 0)
			send_noise();
		if (completes_weight(nib))
			prepare_weight_reads();
		c = random_item(OP_CODE);
		c.code_nibble = nib;
		send_item(c);
	endtask

	// Encode one step as a plain nibble or as an escape with three digits
	task automatic send_weight(input logic [STEP_W-1:0] step, input bit escaped);
		if (!escaped) begin
			send_code(step[3:0]);
		end else begin
			send_code(ESCAPE_CODE);
			send_code(step[3:0]);
			send_code(step[7:4]);
			send_code(step[11:8]);
		end
	endtask

	task automatic send_row(input bit wild);
		int unsigned eff;
		int unsigned pick;
		eff = row_length_now();
		repeat (eff) begin
			pick = $urandom_range(0, 99);
			if (pick < (wild ? 40 : 85))
				send_weight(STEP_W'($urandom_range(0, 14)), 1'b0);
			else if (pick < (wild ? 50 : 95))
				send_weight(STEP_W'($urandom_range(0, 255)), 1'b1);
			else
				send_weight(STEP_W'($urandom), 1'b1);
		end
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			REG_USE_ORDER: order_on = data[0];
			REG_ROW_LEN: row_len_cfg = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Hold until every expected row is in, then let the pipeline settle
	task automatic wait_rows_drained();
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic test_directed();
		// Zero row length acts as one weight per row
		write_register(REG_USE_ORDER, 11'h7FE);
		write_register(REG_ROW_LEN, '0);
		load_vector('0, VALUE_MIN);
		load_vector(SLOT_LAST, VALUE_MAX);
		send_code('0);
		wait_rows_drained();

		// Two full-scale escapes saturate the level
		write_register(REG_ROW_LEN, 11'd2);
		load_vector(10'd1, VALUE_MAX);
		send_weight('1, 1'b1);
		send_weight('1, 1'b1);
		send_ignored();
		wait_rows_drained();

		// Gather through the order table, with a load inside an escape
		write_register(REG_USE_ORDER, 11'd1);
		load_order('0, SLOT_LAST);
		load_order(10'd1, '0);
		send_code(NIBBLE_STEP_MAX);
		send_code(ESCAPE_CODE);
		load_vector('0, 16'sh5A5A);
		send_code(4'd1);
		send_code('0);
		send_code('0);
	endtask

	task automatic test_random_rows();
		int unsigned           start_count;
		int unsigned           pick;
		logic [CFG_DATA_W-1:0] len;
		noise_on = 1'b1;
		start_count = items_taken;
		while (items_taken - start_count < 750) begin
			wait_rows_drained();
			write_register(REG_USE_ORDER, CFG_DATA_W'($urandom));
			pick = $urandom_range(0, 19);
			if (pick < 14)
				len = CFG_DATA_W'($urandom_range(0, 8));
			else if (pick < 19)
				len = CFG_DATA_W'($urandom_range(9, 40));
			else
				len = CFG_DATA_W'($urandom_range(41, 100));
			write_register(REG_ROW_LEN, len);
			if ($urandom_range(0, 3) == 0)
				write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					CFG_DATA_W'($urandom));
			repeat ($urandom_range(2, 10)) send_row($urandom_range(0, 3) == 0);
		end
		noise_on = 1'b0;
	endtask

	// Result-side stall pattern
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(RX_FREE, RX_SLOW);
			stall_left = $urandom_range(1, 60);
		end
		stall_left--;
		case (stall_mode)
			RX_FREE: res_ch.ready = 1'b1;
			RX_COIN: res_ch.ready = ($urandom_range(0, 1) == 0);
			default: res_ch.ready = ($urandom_range(0, 3) == 0);
		endcase
	end

	// Compare each accepted row result with the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_rows.size() == 0) begin
				$error("row result with none expected: row_sum %0d, level_overflow %0d",
					$signed(res_ch.payload.row_sum), res_ch.payload.level_overflow);
				error_count++;
			end else begin
				want = expected_rows.pop_front();
				if (res_ch.payload.row_sum !== want.row_sum) begin
					$error("row_sum: expected %0d, actual %0d",
						$signed(want.row_sum), $signed(res_ch.payload.row_sum));
					error_count++;
				end
				if (res_ch.payload.level_overflow !== want.level_overflow) begin
					$error("level_overflow: expected %0d, actual %0d",
						want.level_overflow, res_ch.payload.level_overflow);
					error_count++;
				end
			end
		end
	end

	initial begin
		#10ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_USE_ORDER;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.payload = '0;
		order_on = 1'b0;
		row_len_cfg = ROW_LEN_RESET;
		restart_row();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_rows();
		wait_rows_drained();

		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/scrd_pkg.sv
rtl/core/scrd_chan_if.sv
rtl/core/scrd_ram.sv
rtl/core/scrd_decode.sv
rtl/core/scrd_mac.sv
rtl/core/step_coded_row_dot_product_unit.sv
bench/testbench.sv
